// ----- sv/tws_pkg.sv -----
// tws_pkg: shared types, constants and address helpers for the text window engine
// no dependencies; imported by the top level, tws_csr, tws_ctrl and tws_checker

package tws_pkg;

   localparam int ROW_STRIDE  = 80;
   localparam int STORE_CELLS = 2048;
   localparam int ADDR_W      = $clog2(STORE_CELLS);
   localparam int CELL_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int ROW_W       = 5;
   localparam int COL_W       = 7;
   localparam int KIND_W      = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int ABS_W       = 14;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [KIND_W-1:0] {
      OP_ADVANCE   = 4'd0,
      OP_BACK      = 4'd1,
      OP_NEXT_ROW  = 4'd2,
      OP_FIRST_COL = 4'd3,
      OP_CLEAR     = 4'd4,
      OP_DRAW      = 4'd5,
      OP_UNDRAW    = 4'd6,
      OP_WRITE     = 4'd7,
      OP_READ      = 4'd8
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_ROW   = 3'd0,
      CSR_FIRST_COL   = 3'd1,
      CSR_ROW_LIMIT   = 3'd2,
      CSR_COL_LIMIT   = 3'd3,
      CSR_DEFAULT_ATT = 3'd4,
      CSR_GLYPH       = 3'd5,
      CSR_CURSOR_ATT  = 3'd6
   } csr_idx_type;

   typedef struct packed {
      row_type  first_row;
      col_type  first_col;
      row_type  row_limit;
      col_type  col_limit;
      byte_type default_attr;
      byte_type glyph;
      byte_type cursor_attr;
   } cfg_type;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      cell_type wdata;
      addr_type raddr;
   } mem_req_type;

   localparam cfg_type  CFG_RESET   = cfg_type'{5'd0, 7'd0, 5'd25, 7'd80, 8'h07, 8'd32, 8'h70};
   localparam cell_type SAVED_RESET = 16'h0700;

   // absolute cell address, wrapped to the store size
   function automatic addr_type cell_at(cfg_type cfg, logic [ROW_W:0] row, col_type col);
      logic [ABS_W-1:0] abs_row;
      logic [ABS_W-1:0] sum;
      abs_row = ABS_W'(cfg.first_row) + ABS_W'(row);
      sum = abs_row * ABS_W'(ROW_STRIDE) + ABS_W'(cfg.first_col) + ABS_W'(col);
      return sum[ADDR_W-1:0];
   endfunction

   // last window row, a degenerate window counts as one row
   function automatic row_type last_row(cfg_type cfg);
      return (cfg.row_limit > cfg.first_row) ?
             row_type'(cfg.row_limit - cfg.first_row - 5'd1) : '0;
   endfunction

   function automatic col_type last_col(cfg_type cfg);
      return (cfg.col_limit > cfg.first_col) ?
             col_type'(cfg.col_limit - cfg.first_col - 7'd1) : '0;
   endfunction

endpackage

// ----- sv/text_window_cursor_scroll_engine_core.sv -----
// text_window_cursor_scroll_engine_core: top level of the text window cursor and scroll engine
// depends on tws_pkg, tws_csr, tws_ctrl and tws_ram
//
//   channel  ports                         handshake
//   request  req_kind/cell_value/read_addr start high while busy low
//   result   rsp_* fields                  rsp_valid one-cycle strobe
//   config   csr_index, csr_write_data     csr_write_enable, no wait
//
// cursor moves, draw/undraw, write and read: one screen ram read while idle, then one write,
// a capture or a cursor update; the result strobes in the cycle after that
// scroll: rows copied up with a read and a write per cell; clear: one ram write per cell
// after reset busy stays high while the ram is zeroed
// results cannot be held off; each beat is shown for exactly one cycle

module text_window_cursor_scroll_engine_core
   import tws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [CELL_W-1:0]     req_cell_value,
   input  logic [ADDR_W-1:0]     req_read_address,
   output logic                  rsp_valid,
   output logic [ROW_W-1:0]      rsp_cursor_row_out,
   output logic [COL_W-1:0]      rsp_cursor_col_out,
   output logic [ADDR_W-1:0]     rsp_cell_address,
   output logic                  rsp_scrolled,
   output logic                  rsp_at_top,
   output logic [CELL_W-1:0]     rsp_read_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type     cfg;
   mem_req_type mem_req;
   cell_type    mem_rdata;

   tws_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tws_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_cell_value     (req_cell_value),
      .req_read_address   (req_read_address),
      .mem_req            (mem_req),
      .mem_rdata          (mem_rdata),
      .rsp_valid          (rsp_valid),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_cell_address   (rsp_cell_address),
      .rsp_scrolled       (rsp_scrolled),
      .rsp_at_top         (rsp_at_top),
      .rsp_read_data      (rsp_read_data)
   );

   tws_ram #(
      .WIDTH (CELL_W),
      .DEPTH (STORE_CELLS)
   ) u_screen_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

endmodule

// ----- sv/tws_ram.sv -----
// tws_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies

module tws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/tws_csr.sv -----
// tws_csr: window and cursor configuration registers behind a plain write port
// depends on tws_pkg

module tws_csr
   import tws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FIRST_ROW:   cfg_in.first_row    = csr_write_data[ROW_W-1:0];
            CSR_FIRST_COL:   cfg_in.first_col    = csr_write_data[COL_W-1:0];
            CSR_ROW_LIMIT:   cfg_in.row_limit    = csr_write_data[ROW_W-1:0];
            CSR_COL_LIMIT:   cfg_in.col_limit    = csr_write_data[COL_W-1:0];
            CSR_DEFAULT_ATT: cfg_in.default_attr = csr_write_data[BYTE_W-1:0];
            CSR_GLYPH:       cfg_in.glyph        = csr_write_data[BYTE_W-1:0];
            CSR_CURSOR_ATT:  cfg_in.cursor_attr  = csr_write_data[BYTE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/tws_ctrl.sv -----
// tws_ctrl: operation sequencer, cursor state and window walker around the screen ram
// depends on tws_pkg; drives the ram through a mem_req_type bundle

module tws_ctrl
   import tws_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  cell_type            req_cell_value,
   input  addr_type            req_read_address,
   output mem_req_type         mem_req,
   input  cell_type            mem_rdata,
   output logic                rsp_valid,
   output row_type             rsp_cursor_row_out,
   output col_type             rsp_cursor_col_out,
   output addr_type            rsp_cell_address,
   output logic                rsp_scrolled,
   output logic                rsp_at_top,
   output cell_type            rsp_read_data
);

   typedef enum logic [5:0] {
      ST_WIPE    = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_EXEC    = 6'b000100,
      ST_COPY_RD = 6'b001000,
      ST_COPY_WR = 6'b010000,
      ST_FILL    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   addr_type  wipe_ff, wipe_in;
   row_type   cursor_row_ff, cursor_row_in;
   col_type   cursor_col_ff, cursor_col_in;
   cell_type  saved_ff, saved_in;
   row_type   walk_row_ff, walk_row_in;
   col_type   walk_col_ff, walk_col_in;
   op_type    kind_ff, kind_in;
   cell_type  value_ff, value_in;
   logic      scrolled_ff, scrolled_in;

   logic      rsp_valid_ff, rsp_valid_in;
   row_type   rsp_row_ff;
   col_type   rsp_col_ff;
   addr_type  rsp_addr_ff;
   logic      rsp_scrolled_ff, rsp_scrolled_in;
   logic      rsp_at_top_ff, rsp_at_top_in;
   cell_type  rsp_read_ff, rsp_read_in;

   row_type   hm1;
   col_type   wm1;
   addr_type  cur_addr;
   addr_type  walk_addr;
   addr_type  src_addr;
   addr_type  next_addr;
   logic      finish;
   logic      wrap;

   assign hm1       = last_row(cfg);
   assign wm1       = last_col(cfg);
   assign cur_addr  = cell_at(cfg, {1'b0, cursor_row_ff}, cursor_col_ff);
   assign walk_addr = cell_at(cfg, {1'b0, walk_row_ff}, walk_col_ff);
   assign src_addr  = cell_at(cfg, {1'b0, walk_row_ff} + 6'd1, walk_col_ff);
   assign next_addr = cell_at(cfg, {1'b0, cursor_row_in}, cursor_col_in);

   always_comb begin
      state_in        = state_ff;
      wipe_in         = wipe_ff;
      cursor_row_in   = cursor_row_ff;
      cursor_col_in   = cursor_col_ff;
      saved_in        = saved_ff;
      walk_row_in     = walk_row_ff;
      walk_col_in     = walk_col_ff;
      kind_in         = kind_ff;
      value_in        = value_ff;
      scrolled_in     = scrolled_ff;
      finish          = 1'b0;
      wrap            = 1'b0;
      rsp_scrolled_in = 1'b0;
      rsp_at_top_in   = 1'b0;
      rsp_read_in     = '0;
      mem_req.we      = 1'b0;
      mem_req.waddr   = walk_addr;
      mem_req.wdata   = '0;
      mem_req.raddr   = cur_addr;

      unique case (state_ff)
         ST_WIPE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wipe_ff;
            wipe_in       = wipe_ff + 1'b1;
            if (wipe_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               kind_in  = op_type'(req_kind);
               value_in = req_cell_value;
               state_in = ST_EXEC;
               if (op_type'(req_kind) == OP_READ) begin
                  mem_req.raddr = req_read_address;
               end
            end
         end
         ST_EXEC: begin
            finish = 1'b1;
            unique case (kind_ff)
               OP_ADVANCE, OP_NEXT_ROW: begin
                  wrap = (kind_ff == OP_NEXT_ROW) || !(cursor_col_ff < wm1);
                  if (!wrap) begin
                     cursor_col_in = cursor_col_ff + 1'b1;
                  end else begin
                     cursor_col_in = '0;
                     if (cursor_row_ff < hm1) begin
                        cursor_row_in = cursor_row_ff + 1'b1;
                     end else if (cursor_row_ff == hm1) begin
                        finish      = 1'b0;
                        scrolled_in = 1'b1;
                        walk_col_in = '0;
                        if (hm1 == '0) begin
                           walk_row_in = hm1;
                           state_in    = ST_FILL;
                        end else begin
                           walk_row_in = '0;
                           state_in    = ST_COPY_RD;
                        end
                     end else begin
                        cursor_row_in = hm1;
                     end
                  end
               end
               OP_BACK: begin
                  if (cursor_col_ff != '0) begin
                     cursor_col_in = cursor_col_ff - 1'b1;
                  end else if (cursor_row_ff == '0) begin
                     rsp_at_top_in = 1'b1;
                  end else begin
                     cursor_row_in = cursor_row_ff - 1'b1;
                     cursor_col_in = wm1;
                  end
               end
               OP_FIRST_COL: begin
                  cursor_col_in = '0;
               end
               OP_CLEAR: begin
                  finish        = 1'b0;
                  scrolled_in   = 1'b0;
                  cursor_row_in = '0;
                  cursor_col_in = '0;
                  saved_in      = {cfg.default_attr, saved_ff[BYTE_W-1:0]};
                  walk_row_in   = '0;
                  walk_col_in   = '0;
                  state_in      = ST_FILL;
               end
               OP_DRAW: begin
                  saved_in      = mem_rdata;
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cur_addr;
                  mem_req.wdata = {cfg.cursor_attr, cfg.glyph};
               end
               OP_UNDRAW: begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cur_addr;
                  mem_req.wdata = saved_ff;
               end
               OP_WRITE: begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cur_addr;
                  mem_req.wdata = value_ff;
               end
               OP_READ: begin
                  rsp_read_in = mem_rdata;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY_RD: begin
            mem_req.raddr = src_addr;
            state_in      = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = mem_rdata;
            state_in      = ST_COPY_RD;
            if (walk_col_ff == wm1) begin
               walk_col_in = '0;
               if (walk_row_ff + 1'b1 == hm1) begin
                  walk_row_in = hm1;
                  state_in    = ST_FILL;
               end else begin
                  walk_row_in = walk_row_ff + 1'b1;
               end
            end else begin
               walk_col_in = walk_col_ff + 1'b1;
            end
         end
         ST_FILL: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = {cfg.default_attr, {BYTE_W{1'b0}}};
            if (walk_col_ff == wm1) begin
               walk_col_in = '0;
               if (walk_row_ff == hm1) begin
                  finish          = 1'b1;
                  rsp_scrolled_in = scrolled_ff;
                  state_in        = ST_IDLE;
               end else begin
                  walk_row_in = walk_row_ff + 1'b1;
               end
            end else begin
               walk_col_in = walk_col_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WIPE;
         wipe_ff       <= '0;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         saved_ff      <= SAVED_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wipe_ff       <= wipe_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         saved_ff      <= saved_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_row_ff <= walk_row_in;
      walk_col_ff <= walk_col_in;
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      scrolled_ff <= scrolled_in;
      if (finish) begin
         rsp_row_ff      <= cursor_row_in;
         rsp_col_ff      <= cursor_col_in;
         rsp_addr_ff     <= next_addr;
         rsp_scrolled_ff <= rsp_scrolled_in;
         rsp_at_top_ff   <= rsp_at_top_in;
         rsp_read_ff     <= rsp_read_in;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cell_address   = rsp_addr_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;
   assign rsp_at_top         = rsp_at_top_ff;
   assign rsp_read_data      = rsp_read_ff;

endmodule

// ----- sv/tws_checker.sv -----
// tws_checker: port-level checks on the text window engine top level
// depends on tws_pkg; bound to text_window_cursor_scroll_engine_core below

module tws_checker
   import tws_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [ROW_W-1:0]      rsp_cursor_row_out,
   input logic [COL_W-1:0]      rsp_cursor_col_out,
   input logic                  rsp_scrolled,
   input logic                  rsp_at_top,
   input logic [CELL_W-1:0]     rsp_read_data
);

   // a result beat always lands with the engine free again
   a_rsp_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats back to back");

   a_top_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_at_top) |->
         (rsp_cursor_row_out == '0 && rsp_cursor_col_out == '0 && !rsp_scrolled))
      else $error("refused back not at window origin");

   a_scroll_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_cursor_col_out == '0 && rsp_read_data == '0))
      else $error("scroll left cursor off first column");

endmodule

bind text_window_cursor_scroll_engine_core tws_checker u_tws_checker (.*);
